@@ hdl/thc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thc_pkg
// Shared types and constants of the twelve-hour clock: the command word
// passed from the front end to the back end and the digit formats.
// ----------------------------------------------------------------------------
package thc_pkg;

    // Work for the back end. It is decoded from one input beat.
    typedef struct packed {
        logic tick;
        logic minute_up;
        logic minute_down;
        logic hour_up;
        logic hour_down;
    } thc_cmd_t;

    // A value from 0 to 59 held as two BCD digits.
    typedef struct packed {
        logic [2:0] tens;
        logic [3:0] units;
    } bcd60_t;

    localparam logic [3:0] DIGIT_MAX  = 4'd9;
    localparam logic [2:0] TENS_MAX   = 3'd5;
    localparam logic [3:0] HOUR_FIRST = 4'd1;
    localparam logic [3:0] HOUR_MAX   = 4'd12;
    localparam logic [3:0] DEC_BASE   = 4'd10;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

endpackage

@@ hdl/twelve_hour_clock_with_set_buttons.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twelve_hour_clock_with_set_buttons
// Twelve-hour BCD clock with four active-low set buttons.
// ----------------------------------------------------------------------------
// Path: an input beat is written into the command queue; the back end takes
// it from the queue head into the output register.
// Throughput: one beat per cycle unless out_ready stalls, set by the counter
// update in the back end; a two-entry queue separates input and output stalls.
// Reset: time is 12:00:00, all buttons are taken as released, and no
// result is pending.
module twelve_hour_clock_with_set_buttons (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       tick_second,
    input  logic       minute_up_level,
    input  logic       minute_down_level,
    input  logic       hour_up_level,
    input  logic       hour_down_level,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       hour_tens,
    output logic [3:0] hour_units,
    output logic [2:0] minute_tens,
    output logic [3:0] minute_units,
    output logic [2:0] second_tens,
    output logic [3:0] second_units
);
    import thc_pkg::*;

    logic      push, pop, queue_full, queue_not_empty;
    thc_cmd_t  push_cmd, head_cmd;

    thc_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .tick_second       (tick_second),
        .minute_up_level   (minute_up_level),
        .minute_down_level (minute_down_level),
        .hour_up_level     (hour_up_level),
        .hour_down_level   (hour_down_level),
        .queue_full        (queue_full),
        .push              (push),
        .push_cmd          (push_cmd)
    );

    thc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head_cmd  (head_cmd)
    );

    thc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (queue_not_empty),
        .cmd          (head_cmd),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hour_tens    (hour_tens),
        .hour_units   (hour_units),
        .minute_tens  (minute_tens),
        .minute_units (minute_units),
        .second_tens  (second_tens),
        .second_units (second_units)
    );

endmodule

@@ hdl/thc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thc_front
// Input side: accepts beats and detects falling edges on the four set
// buttons. It passes one command per beat to the queue.
// ----------------------------------------------------------------------------
module thc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              tick_second,
    input  logic              minute_up_level,
    input  logic              minute_down_level,
    input  logic              hour_up_level,
    input  logic              hour_down_level,
    input  logic              queue_full,
    output logic              push,
    output thc_pkg::thc_cmd_t push_cmd
);
    import thc_pkg::*;

    logic prev_mu_reg, prev_md_reg, prev_hu_reg, prev_hd_reg;

    assign in_ready = !queue_full;
    assign push     = in_valid && in_ready;

    // A press counts only when the level was released on the previous beat.
    assign push_cmd.tick        = tick_second;
    assign push_cmd.minute_up   = prev_mu_reg && !minute_up_level;
    assign push_cmd.minute_down = prev_md_reg && !minute_down_level;
    assign push_cmd.hour_up     = prev_hu_reg && !hour_up_level;
    assign push_cmd.hour_down   = prev_hd_reg && !hour_down_level;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_mu_reg <= 1'b1;
            prev_md_reg <= 1'b1;
            prev_hu_reg <= 1'b1;
            prev_hd_reg <= 1'b1;
        end
        else if (push)
        begin
            prev_mu_reg <= minute_up_level;
            prev_md_reg <= minute_down_level;
            prev_hu_reg <= hour_up_level;
            prev_hd_reg <= hour_down_level;
        end
    end

endmodule

@@ hdl/thc_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thc_queue
// Two-entry command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module thc_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  thc_pkg::thc_cmd_t push_cmd,
    input  logic              pop,
    output logic              full,
    output logic              not_empty,
    output thc_pkg::thc_cmd_t head_cmd
);
    import thc_pkg::*;

    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    thc_cmd_t             entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]        count_reg, count_next;

    assign full      = (count_reg == CW'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QUEUE_AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QUEUE_AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ hdl/thc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thc_back
// Time keeping: applies one command per cycle, unless out_ready stalls, to the
// BCD time counters and holds the resulting digits in the output register.
// ----------------------------------------------------------------------------
module thc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  thc_pkg::thc_cmd_t cmd,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              hour_tens,
    output logic [3:0]        hour_units,
    output logic [2:0]        minute_tens,
    output logic [3:0]        minute_units,
    output logic [2:0]        second_tens,
    output logic [3:0]        second_units
);
    import thc_pkg::*;

    function automatic logic is_last(input bcd60_t v);
        return (v.tens == TENS_MAX) && (v.units == DIGIT_MAX);
    endfunction

    function automatic bcd60_t bcd60_inc(input bcd60_t v);
        bcd60_t r;
        r = v;
        if (v.units == DIGIT_MAX)
        begin
            r.units = '0;
            r.tens  = (v.tens == TENS_MAX) ? '0 : v.tens + 3'd1;
        end
        else
        begin
            r.units = v.units + 4'd1;
        end
        return r;
    endfunction

    function automatic bcd60_t bcd60_dec(input bcd60_t v);
        bcd60_t r;
        r = v;
        if (v.units == '0)
        begin
            r.units = DIGIT_MAX;
            r.tens  = (v.tens == '0) ? TENS_MAX : v.tens - 3'd1;
        end
        else
        begin
            r.units = v.units - 4'd1;
        end
        return r;
    endfunction

    function automatic logic [3:0] hour_inc(input logic [3:0] h);
        return (h >= HOUR_MAX) ? HOUR_FIRST : h + 4'd1;
    endfunction

    function automatic logic [3:0] hour_dec(input logic [3:0] h);
        return (h <= HOUR_FIRST || h > HOUR_MAX) ? HOUR_MAX : h - 4'd1;
    endfunction

    bcd60_t     sec_reg, sec_next;
    bcd60_t     min_reg, min_next;
    logic [3:0] hour_reg, hour_next;
    logic       out_valid_reg, out_valid_next;
    logic       hour_tens_reg;
    logic [3:0] hour_units_reg;
    bcd60_t     min_out_reg;
    bcd60_t     sec_out_reg;
    logic       hour_ge_ten;

    // A new command is taken whenever the output register is free or drains.
    assign pop = cmd_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        sec_next  = sec_reg;
        min_next  = min_reg;
        hour_next = hour_reg;
        if (cmd.tick)
        begin
            if (is_last(sec_reg))
            begin
                if (is_last(min_reg))
                begin
                    hour_next = hour_inc(hour_reg);
                end
                min_next = bcd60_inc(min_reg);
            end
            sec_next = bcd60_inc(sec_reg);
        end
        if (cmd.minute_up)
        begin
            min_next = bcd60_inc(min_next);
        end
        if (cmd.minute_down)
        begin
            min_next = bcd60_dec(min_next);
        end
        if (cmd.hour_up)
        begin
            hour_next = hour_inc(hour_next);
        end
        if (cmd.hour_down)
        begin
            hour_next = hour_dec(hour_next);
        end
        if (cmd.minute_up || cmd.minute_down || cmd.hour_up || cmd.hour_down)
        begin
            sec_next = '0;
        end
        hour_ge_ten    = (hour_next >= DEC_BASE);
        out_valid_next = pop || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec_reg       <= '0;
            min_reg       <= '0;
            hour_reg      <= HOUR_MAX;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                sec_reg  <= sec_next;
                min_reg  <= min_next;
                hour_reg <= hour_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            hour_tens_reg  <= hour_ge_ten;
            hour_units_reg <= hour_ge_ten ? hour_next - DEC_BASE : hour_next;
            min_out_reg    <= min_next;
            sec_out_reg    <= sec_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign hour_tens    = hour_tens_reg;
    assign hour_units   = hour_units_reg;
    assign minute_tens  = min_out_reg.tens;
    assign minute_units = min_out_reg.units;
    assign second_tens  = sec_out_reg.tens;
    assign second_units = sec_out_reg.units;

endmodule

@@ tb/twelve_hour_clock_with_set_buttons_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twelve_hour_clock_with_set_buttons_test
// Self-checking bench for the twelve-hour BCD clock with set buttons. A short
// scripted sequence covers wraps, held buttons and tick-with-press. Random
// tick runs, button presses, carry set-ups and noise follow. Every result beat
// is compared digit by digit against its typed script digits, if any, or a
// clock model in the bench. Random gaps and stalls are applied on both channels.
// ----------------------------------------------------------------------------
module twelve_hour_clock_with_set_buttons_test;
    import thc_pkg::*;

    typedef struct packed {
        logic tick;
        logic min_up;
        logic min_dn;
        logic hr_up;
        logic hr_dn;
    } button_beat_t;

    typedef struct packed {
        logic       h_tens;
        logic [3:0] h_units;
        logic [2:0] m_tens;
        logic [3:0] m_units;
        logic [2:0] s_tens;
        logic [3:0] s_units;
    } time_digits_t;

    typedef struct packed {
        button_beat_t beat;
        logic         known;
        time_digits_t digits;
    } script_row_t;

    // Button levels are active low.
    localparam logic REL = 1'b1;
    localparam logic PRS = 1'b0;

    // Bit positions of the buttons in a level vector {min_up, min_dn, hr_up, hr_dn}.
    localparam int BTN_MIN_UP = 3;
    localparam int BTN_MIN_DN = 2;
    localparam int BTN_HR_UP  = 1;
    localparam int BTN_HR_DN  = 0;

    localparam logic [3:0] ALL_RELEASED = 4'b1111;
    localparam logic [5:0] SEC_WRAP     = 6'd60;
    localparam logic [5:0] MIN_LAST     = 6'd59;

    localparam int NUM_ITEMS      = 1350;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 8;
    localparam int MAX_REPORTS    = 40;

    localparam time_digits_t T12_00_00 = '{1'b1, 4'd2, 3'd0, 4'd0, 3'd0, 4'd0};
    localparam time_digits_t T12_00_01 = '{1'b1, 4'd2, 3'd0, 4'd0, 3'd0, 4'd1};
    localparam time_digits_t T12_59_00 = '{1'b1, 4'd2, 3'd5, 4'd9, 3'd0, 4'd0};
    localparam time_digits_t T01_00_00 = '{1'b0, 4'd1, 3'd0, 4'd0, 3'd0, 4'd0};
    localparam time_digits_t T12_01_00 = '{1'b1, 4'd2, 3'd0, 4'd1, 3'd0, 4'd0};
    localparam time_digits_t NO_DIGITS = '0;

    // Columns: {tick, min_up, min_dn, hr_up, hr_dn}, typed result present, typed result.
    localparam int SCRIPT_LEN = 20;
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        '{'{1'b0, REL, REL, REL, REL}, 1'b1, T12_00_00},
        '{'{1'b1, REL, REL, REL, REL}, 1'b1, T12_00_01},
        '{'{1'b0, REL, PRS, REL, REL}, 1'b1, T12_59_00},
        '{'{1'b0, REL, PRS, REL, REL}, 1'b1, T12_59_00},
        '{'{1'b0, PRS, REL, REL, REL}, 1'b1, T12_00_00},
        '{'{1'b0, REL, REL, PRS, REL}, 1'b1, T01_00_00},
        '{'{1'b0, REL, REL, REL, PRS}, 1'b1, T12_00_00},
        '{'{1'b1, REL, REL, REL, REL}, 1'b0, NO_DIGITS},
        '{'{1'b1, PRS, REL, REL, REL}, 1'b1, T12_01_00},
        '{'{1'b1, REL, REL, REL, REL}, 1'b0, NO_DIGITS},
        '{'{1'b0, PRS, PRS, PRS, PRS}, 1'b0, NO_DIGITS},
        '{'{1'b1, PRS, PRS, PRS, PRS}, 1'b0, NO_DIGITS},
        '{'{1'b0, REL, REL, REL, REL}, 1'b0, NO_DIGITS},
        '{'{1'b0, REL, REL, PRS, REL}, 1'b0, NO_DIGITS},
        '{'{1'b0, REL, REL, REL, REL}, 1'b0, NO_DIGITS},
        '{'{1'b0, REL, REL, REL, PRS}, 1'b0, NO_DIGITS},
        '{'{1'b0, REL, REL, REL, REL}, 1'b0, NO_DIGITS},
        '{'{1'b0, REL, REL, REL, PRS}, 1'b0, NO_DIGITS},
        '{'{1'b1, REL, REL, REL, REL}, 1'b0, NO_DIGITS},
        '{'{1'b0, REL, REL, PRS, REL}, 1'b0, NO_DIGITS}
    };

    logic       clk;
    logic       rst_n             = 1'b0;
    logic       in_valid          = 1'b0;
    logic       in_ready;
    logic       tick_second       = 1'b0;
    logic       minute_up_level   = 1'b1;
    logic       minute_down_level = 1'b1;
    logic       hour_up_level     = 1'b1;
    logic       hour_down_level   = 1'b1;
    logic       out_valid;
    logic       out_ready         = 1'b0;
    logic       hour_tens;
    logic [3:0] hour_units;
    logic [2:0] minute_tens;
    logic [3:0] minute_units;
    logic [2:0] second_tens;
    logic [3:0] second_units;

    // Typed result that travels with the beat being offered.
    logic         row_known  = 1'b0;
    time_digits_t row_digits = '0;
    bit           no_stall   = 1'b0;

    // Clock model state.
    logic [5:0] sec_cnt  = 6'd0;
    logic [5:0] min_cnt  = 6'd0;
    logic [3:0] hour_cnt = HOUR_MAX;
    logic [3:0] prev_lvl = ALL_RELEASED;

    time_digits_t digits_due [$];
    int errors       = 0;
    int beats_in     = 0;
    int results_seen = 0;
    int edges_seen   = 0;
    int hour_rolls   = 0;
    int idle_cycles  = 0;
    int rdy_hold     = 0;

    twelve_hour_clock_with_set_buttons dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .tick_second      (tick_second),
        .minute_up_level  (minute_up_level),
        .minute_down_level(minute_down_level),
        .hour_up_level    (hour_up_level),
        .hour_down_level  (hour_down_level),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .hour_tens        (hour_tens),
        .hour_units       (hour_units),
        .minute_tens      (minute_tens),
        .minute_units     (minute_units),
        .second_tens      (second_tens),
        .second_units     (second_units)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [3:0] hour_after(logic [3:0] h);
        return (h >= HOUR_MAX) ? HOUR_FIRST : h + 4'd1;
    endfunction

    // Applies one beat to the clock model and returns the digits it shows.
    function automatic time_digits_t advance_clock(button_beat_t b);
        time_digits_t d;
        if (b.tick)
        begin
            sec_cnt = sec_cnt + 6'd1;
            if (sec_cnt >= SEC_WRAP)
            begin
                sec_cnt = '0;
                min_cnt = min_cnt + 6'd1;
                if (min_cnt >= SEC_WRAP)
                begin
                    min_cnt  = '0;
                    hour_cnt = hour_after(hour_cnt);
                    hour_rolls++;
                end
            end
        end
        if (prev_lvl[BTN_MIN_UP] && !b.min_up)
        begin
            min_cnt = (min_cnt >= MIN_LAST) ? 6'd0 : min_cnt + 6'd1;
            sec_cnt = '0;
            edges_seen++;
        end
        if (prev_lvl[BTN_MIN_DN] && !b.min_dn)
        begin
            min_cnt = (min_cnt == 6'd0 || min_cnt > MIN_LAST) ? MIN_LAST : min_cnt - 6'd1;
            sec_cnt = '0;
            edges_seen++;
        end
        if (prev_lvl[BTN_HR_UP] && !b.hr_up)
        begin
            hour_cnt = hour_after(hour_cnt);
            sec_cnt  = '0;
            edges_seen++;
        end
        if (prev_lvl[BTN_HR_DN] && !b.hr_dn)
        begin
            hour_cnt = (hour_cnt <= HOUR_FIRST || hour_cnt > HOUR_MAX)
                       ? HOUR_MAX : hour_cnt - 4'd1;
            sec_cnt  = '0;
            edges_seen++;
        end
        prev_lvl  = {b.min_up, b.min_dn, b.hr_up, b.hr_dn};
        d.h_tens  = 1'(hour_cnt / DEC_BASE);
        d.h_units = hour_cnt % DEC_BASE;
        d.m_tens  = 3'(min_cnt / DEC_BASE);
        d.m_units = 4'(min_cnt % DEC_BASE);
        d.s_tens  = 3'(sec_cnt / DEC_BASE);
        d.s_units = 4'(sec_cnt % DEC_BASE);
        return d;
    endfunction

    // Mostly no pause, often a short one, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic check_digit(string what, logic [3:0] want, logic [3:0] got);
        if (got !== want)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    always @(negedge clk)
    begin
        if (no_stall)
        begin
            out_ready <= 1'b1;
            rdy_hold = 0;
        end
        else if (rdy_hold > 0)
            rdy_hold--;
        else
        begin
            out_ready <= ($urandom_range(0, 3) != 0);
            rdy_hold = idle_len();
        end
    end

    always @(posedge clk)
    begin : watch
        button_beat_t b;
        time_digits_t want;
        time_digits_t got;
        time_digits_t pred;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                b = {tick_second, minute_up_level, minute_down_level,
                     hour_up_level, hour_down_level};
                pred = advance_clock(b);
                digits_due.push_back(row_known ? row_digits : pred);
                beats_in++;
            end
            if (out_valid && out_ready)
            begin
                got = {hour_tens, hour_units, minute_tens, minute_units,
                       second_tens, second_units};
                results_seen++;
                if (digits_due.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t ns: result beat %p with nothing expected", $time, got);
                end
                else
                begin
                    want = digits_due.pop_front();
                    check_digit("hour tens", 4'(want.h_tens), 4'(got.h_tens));
                    check_digit("hour units", want.h_units, got.h_units);
                    check_digit("minute tens", 4'(want.m_tens), 4'(got.m_tens));
                    check_digit("minute units", want.m_units, got.m_units);
                    check_digit("second tens", 4'(want.s_tens), 4'(got.s_tens));
                    check_digit("second units", want.s_units, got.s_units);
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t ns: no beat moved for %0d cycles", $time, idle_cycles);
                $display("** twelve_hour_clock_with_set_buttons: FAILED **");
                $finish;
            end
        end
    end

    // Entered and left at a falling edge.
    task automatic send_beat(button_beat_t b, logic known, time_digits_t typed);
        int gap;
        gap = no_stall ? 0 : idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap)
            begin
                {tick_second, minute_up_level, minute_down_level,
                 hour_up_level, hour_down_level} <= 5'($urandom);
                @(negedge clk);
            end
        end
        {tick_second, minute_up_level, minute_down_level,
         hour_up_level, hour_down_level} <= b;
        row_known  <= known;
        row_digits <= typed;
        in_valid   <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_levels(logic tick, logic [3:0] lvl);
        send_beat({tick, lvl}, 1'b0, NO_DIGITS);
    endtask

    // Press one button, hold it a few beats, then let it go.
    task automatic push_button(int idx, int hold);
        logic [3:0] lvl;
        lvl      = ALL_RELEASED;
        lvl[idx] = PRS;
        send_levels(1'($urandom), lvl);
        repeat (hold)
            send_levels(1'($urandom), lvl);
        send_levels(1'($urandom), ALL_RELEASED);
    endtask

    initial
    begin : stimulus
        int n;
        int seg;
        int len;
        logic [3:0] lvl;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (n = 0; n < SCRIPT_LEN; n++)
            send_beat(SCRIPT[n].beat, SCRIPT[n].known, SCRIPT[n].digits);

        while (beats_in < NUM_ITEMS)
        begin
            no_stall = ($urandom_range(0, 5) == 0);
            seg = $urandom_range(0, 99);
            if (seg < 35)
            begin
                len = $urandom_range(1, 80);
                repeat (len)
                    send_levels($urandom_range(0, 9) != 0, ALL_RELEASED);
            end
            else if (seg < 60)
                push_button($urandom_range(0, 3), $urandom_range(0, 3));
            else if (seg < 72)
            begin
                // Park the minutes at 59 with the buttons, then let the seconds
                // run over so the carry goes all the way into the hours.
                if ($urandom_range(0, 1))
                    while (hour_cnt != HOUR_MAX)
                        push_button(BTN_HR_UP, 0);
                if (min_cnt >= 6'd30)
                begin
                    while (min_cnt != MIN_LAST)
                        push_button(BTN_MIN_UP, 0);
                end
                else
                begin
                    while (min_cnt != MIN_LAST)
                        push_button(BTN_MIN_DN, 0);
                end
                len = $urandom_range(60, 62);
                repeat (len)
                    send_levels(1'b1, ALL_RELEASED);
            end
            else if (seg < 88)
            begin
                len = $urandom_range(1, 12);
                repeat (len)
                    send_beat(button_beat_t'(5'($urandom)), 1'b0, NO_DIGITS);
            end
            else
            begin
                // Several buttons held together across ticks.
                lvl = 4'($urandom);
                len = $urandom_range(2, 10);
                repeat (len)
                    send_levels(1'($urandom), lvl);
            end
        end

        in_valid <= 1'b0;
        no_stall = 1'b0;
        while (digits_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d input beats and checked %0d result beats under random stalls.",
                 beats_in, results_seen);
        $display("Button edges acted on: %0d; hour carries from the seconds tick: %0d.",
                 edges_seen, hour_rolls);
        if (errors == 0)
            $display("** twelve_hour_clock_with_set_buttons: PASSED **");
        else
            $display("** twelve_hour_clock_with_set_buttons: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/thc_pkg.sv
hdl/thc_front.sv
hdl/thc_queue.sv
hdl/thc_back.sv
hdl/twelve_hour_clock_with_set_buttons.sv
tb/twelve_hour_clock_with_set_buttons_test.sv
